// ===== hw/rtl/square_ring_neighbourhood_sum_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the square ring neighbourhood sum unit
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SQUARE_RING_NEIGHBOURHOOD_SUM_UNIT_ASSERT_SVH
`define SQUARE_RING_NEIGHBOURHOOD_SUM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// property checked on every clock, muted during reset
`define SRNS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition that must never hold
`define SRNS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SRNS_ASSERT(lbl, prop, msg)
`define SRNS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== hw/rtl/srns_pkg.sv =====
// ----------------------------------------------------------------------------
// srns_pkg
// Shared constants, types and helpers of the ring sum unit.
// ----------------------------------------------------------------------------
`default_nettype none

package srns_pkg;

  localparam int MAX_DIM   = 32;
  localparam int MEM_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int POS_W = 5;   // row / col field width
  localparam int CNT_W = 6;   // row_count / col_count width
  localparam int RAD_W = 5;
  localparam int VAL_W = 16;
  localparam int SUM_W = 23;
  localparam int CRD_W = 7;   // cell coordinate, up to row + radius
  localparam int SC_W  = 8;   // signed ring bound

  localparam int APB_DW  = 32;
  localparam int PADDR_W = 4;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [1:0] REG_COL_COUNT = 2'd1;
  localparam logic [1:0] REG_RADIUS    = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] row_count;
    logic [CNT_W-1:0] col_count;
    logic [RAD_W-1:0] radius;
  } cfg_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  function automatic logic [CNT_W-1:0] eff_dim(input logic [CNT_W-1:0] n);
    return (int'(n) > MAX_DIM) ? CNT_W'(MAX_DIM) : n;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CRD_W-1:0] r,
                                                  input logic [CRD_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/srns_if.sv =====
// ----------------------------------------------------------------------------
// srns_in_if / srns_out_if
// Valid/ready channels for input items and ring sum results.
// ----------------------------------------------------------------------------
`default_nettype none

interface srns_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic [srns_pkg::POS_W-1:0]           row;
  logic [srns_pkg::POS_W-1:0]           col;
  logic signed [srns_pkg::VAL_W-1:0]    value;

  modport source (output valid, action, row, col, value, input ready);
  modport sink   (input valid, action, row, col, value, output ready);
endinterface

interface srns_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [srns_pkg::SUM_W-1:0]    ring_sum;

  modport source (output valid, ring_sum, input ready);
  modport sink   (input valid, ring_sum, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/square_ring_neighbourhood_sum_unit.sv =====
// ----------------------------------------------------------------------------
// square_ring_neighbourhood_sum_unit
// Matrix store with ring-border sum queries and APB-style configuration.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Payload
// in_ch     in   valid/ready        action, row, col, value
// out_ch    out  valid/ready        ring_sum
// apb       in   psel/penable/pready row_count @0x0, col_count @0x4, radius @0x8
//
// A write item is taken in the idle state. A query passes through setup, the
// walk, drain and done (setup goes straight to done when the clipped ring box
// is empty); the walk steps through each in-bounds column of the top and bottom
// ring rows and the left/right edges of each in-bounds middle row via one read port.
// The store has no reset or clearing pass; reset idles control and presets config.
// A finished sum sits in the output register; the next item is taken while
// it waits, and a second sum holds in the walker until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module square_ring_neighbourhood_sum_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  srns_in_if.sink                              in_ch,
  srns_out_if.source                           out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [srns_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [srns_pkg::APB_DW-1:0]     pwdata,
  output logic [srns_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready
);

  logic [srns_pkg::CNT_W-1:0] row_count_r, col_count_r;
  logic [srns_pkg::RAD_W-1:0] radius_r;
  logic                       apb_wr;
  srns_pkg::cfg_t             cfg;
  srns_pkg::mem_req_t         mem_req;
  logic signed [srns_pkg::VAL_W-1:0] rd_data;

  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= srns_pkg::CNT_W'(32);
      col_count_r <= srns_pkg::CNT_W'(32);
      radius_r    <= srns_pkg::RAD_W'(1);
    end else if (apb_wr) begin
      unique case (paddr[3:2])
        srns_pkg::REG_ROW_COUNT: row_count_r <= pwdata[srns_pkg::CNT_W-1:0];
        srns_pkg::REG_COL_COUNT: col_count_r <= pwdata[srns_pkg::CNT_W-1:0];
        srns_pkg::REG_RADIUS:    radius_r    <= pwdata[srns_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      srns_pkg::REG_ROW_COUNT: prdata = srns_pkg::APB_DW'(row_count_r);
      srns_pkg::REG_COL_COUNT: prdata = srns_pkg::APB_DW'(col_count_r);
      srns_pkg::REG_RADIUS:    prdata = srns_pkg::APB_DW'(radius_r);
      default:                 prdata = '0;
    endcase
  end

  assign cfg.row_count = row_count_r;
  assign cfg.col_count = col_count_r;
  assign cfg.radius    = radius_r;

  srns_walk u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg     (cfg),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  srns_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/srns_store.sv =====
// ----------------------------------------------------------------------------
// srns_store
// Matrix storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srns_store (
  input  wire logic                              clk,
  input  wire srns_pkg::mem_req_t                req,
  output logic signed [srns_pkg::VAL_W-1:0]      rd_data
);

  logic [srns_pkg::VAL_W-1:0] mem [srns_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/srns_walk.sv =====
// ----------------------------------------------------------------------------
// srns_walk
// Input handling, ring walk over the store, accumulation and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "square_ring_neighbourhood_sum_unit_assert.svh"

module srns_walk (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  srns_in_if.sink                            in_ch,
  srns_out_if.source                         out_ch,
  input  wire srns_pkg::cfg_t                cfg,
  output srns_pkg::mem_req_t                 mem_req,
  input  wire logic signed [srns_pkg::VAL_W-1:0] rd_data
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [srns_pkg::CNT_W-1:0] rows_eff, cols_eff;
  logic in_xfer, query_xfer, load;
  logic out_valid_r, out_valid_nxt;

  logic [srns_pkg::POS_W-1:0] q_row_r, q_col_r;
  logic [srns_pkg::CRD_W-1:0] r_r, c_r;
  logic                       slot_r;   // middle row: 0 left edge, 1 right edge
  logic                       pend_r;
  logic signed [srns_pkg::SUM_W-1:0] acc_r, sum_r;

  logic signed [srns_pkg::SC_W-1:0] top_s, bot_s, lft_s, rgt_s, rmax_s, cmax_s;
  logic signed [srns_pkg::SC_W-1:0] r_lo_s, r_hi_s, c_lo_s, c_hi_s;
  logic empty, left_ok, right_ok;
  logic full_row, issue, row_end, last;
  logic [srns_pkg::CRD_W-1:0] cur_c;

  assign rows_eff = srns_pkg::eff_dim(cfg.row_count);
  assign cols_eff = srns_pkg::eff_dim(cfg.col_count);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign query_xfer  = in_xfer && (in_ch.action == srns_pkg::ACT_QUERY);

  // ring bounds clipped to cfg size; cfg static while busy is up to the user
  always_comb begin
    top_s  = srns_pkg::SC_W'(q_row_r) - srns_pkg::SC_W'(cfg.radius);
    bot_s  = srns_pkg::SC_W'(q_row_r) + srns_pkg::SC_W'(cfg.radius);
    lft_s  = srns_pkg::SC_W'(q_col_r) - srns_pkg::SC_W'(cfg.radius);
    rgt_s  = srns_pkg::SC_W'(q_col_r) + srns_pkg::SC_W'(cfg.radius);
    rmax_s = srns_pkg::SC_W'(rows_eff) - srns_pkg::SC_W'(1);
    cmax_s = srns_pkg::SC_W'(cols_eff) - srns_pkg::SC_W'(1);
    r_lo_s = (top_s < 0) ? '0 : top_s;
    c_lo_s = (lft_s < 0) ? '0 : lft_s;
    r_hi_s = (bot_s < rmax_s) ? bot_s : rmax_s;
    c_hi_s = (rgt_s < cmax_s) ? rgt_s : cmax_s;
    empty    = (r_lo_s > r_hi_s) || (c_lo_s > c_hi_s);
    left_ok  = (lft_s >= 0) && (lft_s <= cmax_s);
    right_ok = (rgt_s <= cmax_s);
  end

  // walk step: top/bottom rows sweep in-bounds columns, middle rows hit left/right edges
  always_comb begin
    full_row = (srns_pkg::SC_W'(r_r) == top_s) || (srns_pkg::SC_W'(r_r) == bot_s);
    if (full_row) begin
      cur_c   = c_r;
      issue   = 1'b1;
      row_end = (c_r == srns_pkg::CRD_W'(c_hi_s));
    end else begin
      cur_c   = slot_r ? srns_pkg::CRD_W'(rgt_s) : srns_pkg::CRD_W'(lft_s);
      issue   = slot_r ? right_ok : left_ok;
      row_end = slot_r;
    end
    last = row_end && (r_r == srns_pkg::CRD_W'(r_hi_s));
  end

  // writes go straight to the store; reads only happen while walking,
  // so the two ports never touch the same entry in one cycle
  always_comb begin
    mem_req.wr_en   = in_xfer && (in_ch.action == srns_pkg::ACT_WRITE) &&
                      ({1'b0, in_ch.row} < rows_eff) && ({1'b0, in_ch.col} < cols_eff);
    mem_req.wr_addr = srns_pkg::cell_addr(srns_pkg::CRD_W'(in_ch.row),
                                          srns_pkg::CRD_W'(in_ch.col));
    mem_req.wr_data = in_ch.value;
    mem_req.rd_en   = (state_r == ST_WALK) && issue;
    mem_req.rd_addr = srns_pkg::cell_addr(r_r, cur_c);
  end

  assign load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (query_xfer) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = empty ? ST_DONE : ST_WALK;
      ST_WALK:  if (last) state_nxt = ST_DRAIN;
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  if (load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = (out_valid_r && !out_ch.ready) || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= mem_req.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (query_xfer) begin
      q_row_r <= in_ch.row;
      q_col_r <= in_ch.col;
    end
    if (state_r == ST_SETUP) begin
      r_r    <= srns_pkg::CRD_W'(r_lo_s);
      c_r    <= srns_pkg::CRD_W'(c_lo_s);
      slot_r <= 1'b0;
    end else if (state_r == ST_WALK) begin
      if (row_end) begin
        r_r    <= r_r + srns_pkg::CRD_W'(1);
        c_r    <= srns_pkg::CRD_W'(c_lo_s);
        slot_r <= 1'b0;
      end else begin
        c_r    <= c_r + srns_pkg::CRD_W'(1);
        slot_r <= 1'b1;
      end
    end
    if (query_xfer) begin
      acc_r <= '0;
    end else if (pend_r) begin
      acc_r <= acc_r + srns_pkg::SUM_W'(rd_data);
    end
    if (load) begin
      sum_r <= acc_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.ring_sum = sum_r;

  `SRNS_ASSERT(a_rd_in_bounds, mem_req.rd_en |-> ({1'b0, r_r} < {2'b0, rows_eff}) && ({1'b0, cur_c} < {2'b0, cols_eff}), "ring read outside configured size")
  `SRNS_ASSERT(a_pend_in_walk, pend_r |-> (state_r == ST_WALK || state_r == ST_DRAIN), "read data returned outside the walk")
  `SRNS_ASSERT(a_query_start, query_xfer |=> (state_r == ST_SETUP) && (acc_r == '0), "query did not start a clean walk")
  `SRNS_ASSERT_NEVER(a_rw_overlap, mem_req.wr_en && mem_req.rd_en, "store written and read in one cycle")

endmodule

`default_nettype wire
